// ----- hw/rtl/occ_pkg.sv -----
// ----------------------------------------------------------------------------
// Channel occupancy estimator package
// Shared constants for the channel occupancy estimator: field widths,
// register indexes, reset levels and default sizes.
// ----------------------------------------------------------------------------
package occ_pkg;

    localparam int unsigned SAMPLE_BITS = 13;
    localparam int unsigned CHAN_W      = 7;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam longint unsigned MAX_WINDOW_DEF   = 65535;
    localparam int unsigned     MAX_CHANNELS_DEF = 128;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BUSY_LEVEL  = CFG_IDX_W'(1);

    localparam logic signed [SAMPLE_BITS-1:0] FLOOR_RESET = SAMPLE_BITS'(-150 * 16);
    localparam logic signed [SAMPLE_BITS-1:0] BUSY_RESET  = SAMPLE_BITS'(-85 * 16);

    localparam int unsigned PERCENT_FULL = 100;

endpackage

// ----- hw/rtl/occ_if.sv -----
// ----------------------------------------------------------------------------
// Channel occupancy estimator channels
// Valid/ready channels for power samples, window results and register writes.
// ----------------------------------------------------------------------------
interface occ_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [occ_pkg::SAMPLE_BITS-1:0]     sample_power;
    logic                                       window_end;

    modport source (output valid, output sample_power, output window_end, input ready);
    modport sink (input valid, input sample_power, input window_end, output ready);
endinterface

interface occ_out_if;
    logic                                       valid;
    logic                                       ready;
    logic [occ_pkg::CHAN_W-1:0]                 channel_number;
    logic signed [occ_pkg::SAMPLE_BITS-1:0]     mean_power;
    logic [occ_pkg::PCT_W-1:0]                  occupancy_percent;
    logic                                       empty_window;

    modport source (output valid, output channel_number, output mean_power,
                    output occupancy_percent, output empty_window, input ready);
    modport sink (input valid, input channel_number, input mean_power,
                  input occupancy_percent, input empty_window, output ready);
endinterface

interface occ_cfg_if;
    logic                                       valid;
    logic                                       ready;
    logic [occ_pkg::CFG_IDX_W-1:0]              index;
    logic [occ_pkg::SAMPLE_BITS-1:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/channel_occupancy_estimator.sv -----
// The percentage division is skipped when the busy count reaches the floor count,
// and both divisions are skipped when the window is empty.
// Throughput: one sample per cycle while the queue has room; the back end takes
// one window at a time on a bit-serial divider, behind a two-entry queue.
// Reset: accumulators, channel counter and queue clear; floor -2400, busy -1360.
// ----------------------------------------------------------------------------
// Channel occupancy estimator
// Energy-detection occupancy: per-window mean power above the noise floor
// and busy percentage, with a decoupled accumulate front and divide back.
// ----------------------------------------------------------------------------
module channel_occupancy_estimator #(
    parameter longint unsigned MAX_WINDOW   = occ_pkg::MAX_WINDOW_DEF,
    parameter int unsigned     MAX_CHANNELS = occ_pkg::MAX_CHANNELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    occ_in_if.sink     samples,
    occ_cfg_if.sink    cfg,
    occ_out_if.source  results
);

    localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned SUM_W = CNT_W + occ_pkg::SAMPLE_BITS;
    localparam int unsigned JOB_W = CH_W + SUM_W + 2 * CNT_W;

    logic             push_valid;
    logic             push_ready;
    logic [JOB_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [JOB_W-1:0] pop_data;

    occ_front #(
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg       (cfg),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_data  (push_data)
    );

    occ_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (occ_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    occ_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_data  (pop_data),
        .results   (results)
    );

endmodule

// ----- hw/rtl/occ_queue.sv -----
// ----------------------------------------------------------------------------
// Occupancy job queue
// Small first-in first-out buffer of finished window totals between the
// accumulating front end and the dividing back end.
// ----------------------------------------------------------------------------
module occ_queue #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = occ_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/occ_front.sv -----
// ----------------------------------------------------------------------------
// Occupancy front end
// Compares each sample with the noise floor and busy level, accumulates the
// window totals and hands them to the queue at the end of each window.
// ----------------------------------------------------------------------------
module occ_front #(
    parameter longint unsigned MAX_WINDOW   = occ_pkg::MAX_WINDOW_DEF,
    parameter int unsigned     MAX_CHANNELS = occ_pkg::MAX_CHANNELS_DEF,
    localparam int unsigned    CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int unsigned    CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int unsigned    SUM_W = CNT_W + occ_pkg::SAMPLE_BITS,
    localparam int unsigned    JOB_W = CH_W + SUM_W + 2 * CNT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    occ_in_if.sink           samples,
    occ_cfg_if.sink          cfg,
    output logic             job_valid,
    input  logic             job_ready,
    output logic [JOB_W-1:0] job_data
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW);
    localparam logic [CH_W-1:0]  CH_LAST = CH_W'(MAX_CHANNELS - 1);

    logic signed [occ_pkg::SAMPLE_BITS-1:0] floor_reg;
    logic signed [occ_pkg::SAMPLE_BITS-1:0] busy_reg;
    logic signed [SUM_W-1:0]                sum_reg;
    logic signed [SUM_W-1:0]                sum_next;
    logic signed [SUM_W-1:0]                sum_acc;
    logic [CNT_W-1:0]                       fcnt_reg;
    logic [CNT_W-1:0]                       fcnt_next;
    logic [CNT_W-1:0]                       fcnt_acc;
    logic [CNT_W-1:0]                       bcnt_reg;
    logic [CNT_W-1:0]                       bcnt_next;
    logic [CNT_W-1:0]                       bcnt_acc;
    logic [CH_W-1:0]                        ch_reg;
    logic [CH_W-1:0]                        ch_next;
    logic                                   floor_hit;
    logic                                   busy_hit;
    logic                                   accept;

    assign samples.ready = job_ready;
    assign cfg.ready     = 1'b1;
    assign accept        = samples.valid && samples.ready;
    assign job_valid     = samples.valid && samples.window_end;
    assign job_data      = {ch_reg, sum_acc, fcnt_acc, bcnt_acc};

    always_comb
    begin
        floor_hit = (samples.sample_power > floor_reg) && (fcnt_reg != CNT_MAX);
        busy_hit  = (samples.sample_power > busy_reg) && (bcnt_reg != CNT_MAX);
        sum_acc   = floor_hit ? sum_reg + SUM_W'(samples.sample_power) : sum_reg;
        fcnt_acc  = fcnt_reg + CNT_W'(floor_hit);
        bcnt_acc  = bcnt_reg + CNT_W'(busy_hit);

        sum_next  = sum_reg;
        fcnt_next = fcnt_reg;
        bcnt_next = bcnt_reg;
        ch_next   = ch_reg;
        if (accept)
        begin
            if (samples.window_end)
            begin
                sum_next  = '0;
                fcnt_next = '0;
                bcnt_next = '0;
                ch_next   = (ch_reg == CH_LAST) ? '0 : ch_reg + 1'b1;
            end
            else
            begin
                sum_next  = sum_acc;
                fcnt_next = fcnt_acc;
                bcnt_next = bcnt_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            fcnt_reg  <= '0;
            bcnt_reg  <= '0;
            ch_reg    <= '0;
            floor_reg <= occ_pkg::FLOOR_RESET;
            busy_reg  <= occ_pkg::BUSY_RESET;
        end
        else
        begin
            sum_reg  <= sum_next;
            fcnt_reg <= fcnt_next;
            bcnt_reg <= bcnt_next;
            ch_reg   <= ch_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    occ_pkg::REG_NOISE_FLOOR: floor_reg <= cfg.data;
                    occ_pkg::REG_BUSY_LEVEL:  busy_reg  <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- hw/rtl/occ_back.sv -----
// ----------------------------------------------------------------------------
// Occupancy back end
// Takes one set of window totals at a time and works out the mean power and
// the busy percentage on a shared restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module occ_back #(
    parameter longint unsigned MAX_WINDOW   = occ_pkg::MAX_WINDOW_DEF,
    parameter int unsigned     MAX_CHANNELS = occ_pkg::MAX_CHANNELS_DEF,
    localparam int unsigned    CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int unsigned    CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int unsigned    SUM_W = CNT_W + occ_pkg::SAMPLE_BITS,
    localparam int unsigned    JOB_W = CH_W + SUM_W + 2 * CNT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  logic [JOB_W-1:0] job_data,
    occ_out_if.source        results
);

    localparam int unsigned DVD_W  = SUM_W;
    localparam int unsigned ITER_W = $clog2(DVD_W);
    localparam int unsigned SW     = occ_pkg::SAMPLE_BITS;
    localparam int unsigned PW     = occ_pkg::PCT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MEAN = 4'b0010,
        ST_PCT  = 4'b0100,
        ST_DONE = 4'b1000
    } occ_state_t;

    occ_state_t              state_reg;
    occ_state_t              state_next;
    logic [CH_W-1:0]         job_ch;
    logic signed [SUM_W-1:0] job_sum;
    logic [CNT_W-1:0]        job_fcnt;
    logic [CNT_W-1:0]        job_bcnt;
    logic [CH_W-1:0]         ch_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        busy_reg;
    logic                    neg_reg;
    logic                    empty_reg;
    logic [DVD_W-1:0]        dvd_reg;
    logic [DVD_W-1:0]        dvd_next;
    logic [CNT_W-1:0]        rem_reg;
    logic [CNT_W-1:0]        rem_next;
    logic [ITER_W-1:0]       iter_reg;
    logic [ITER_W-1:0]       iter_next;
    logic [SW-1:0]           mean_reg;
    logic [SW-1:0]           mean_next;
    logic [PW-1:0]           pct_reg;
    logic [PW-1:0]           pct_next;
    logic [CNT_W:0]          rem_shift;
    logic                    q_bit;
    logic [DVD_W-1:0]        dvd_step;
    logic [CNT_W-1:0]        rem_step;
    logic [CNT_W:0]          rem_diff;
    logic                    last_step;
    logic                    out_valid_reg;
    logic [occ_pkg::CHAN_W-1:0] out_ch_reg;
    logic [SW-1:0]           out_mean_reg;
    logic [PW-1:0]           out_pct_reg;
    logic                    out_empty_reg;
    logic                    out_load;

    assign {job_ch, job_sum, job_fcnt, job_bcnt} = job_data;
    assign job_ready = (state_reg == ST_IDLE);

    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, cnt_reg};
    assign q_bit     = (rem_shift >= {1'b0, cnt_reg});
    assign rem_step  = q_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    assign dvd_step  = {dvd_reg[DVD_W-2:0], q_bit};
    assign last_step = (iter_reg == ITER_W'(DVD_W - 1));

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next = state_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        iter_next  = iter_reg;
        mean_next  = mean_reg;
        pct_next   = pct_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    rem_next  = '0;
                    iter_next = '0;
                    dvd_next  = job_sum[SUM_W-1] ? DVD_W'(-job_sum) : DVD_W'(job_sum);
                    if (job_fcnt == '0)
                    begin
                        mean_next  = '0;
                        pct_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MEAN;
                    end
                end
            end
            ST_MEAN:
            begin
                dvd_next  = dvd_step;
                rem_next  = rem_step;
                iter_next = iter_reg + 1'b1;
                if (last_step)
                begin
                    mean_next = neg_reg ? -dvd_step[SW-1:0] : dvd_step[SW-1:0];
                    rem_next  = '0;
                    iter_next = '0;
                    if (busy_reg >= cnt_reg)
                    begin
                        pct_next   = PW'(occ_pkg::PERCENT_FULL);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        dvd_next   = DVD_W'(busy_reg) * DVD_W'(occ_pkg::PERCENT_FULL);
                        state_next = ST_PCT;
                    end
                end
            end
            ST_PCT:
            begin
                dvd_next  = dvd_step;
                rem_next  = rem_step;
                iter_next = iter_reg + 1'b1;
                if (last_step)
                begin
                    pct_next   = dvd_step[PW-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        iter_reg <= iter_next;
        mean_reg <= mean_next;
        pct_reg  <= pct_next;
        if (job_valid && job_ready)
        begin
            ch_reg    <= job_ch;
            cnt_reg   <= job_fcnt;
            busy_reg  <= job_bcnt;
            neg_reg   <= job_sum[SUM_W-1];
            empty_reg <= (job_fcnt == '0);
        end
        if (out_load)
        begin
            out_ch_reg    <= occ_pkg::CHAN_W'(ch_reg);
            out_mean_reg  <= mean_reg;
            out_pct_reg   <= pct_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.channel_number    = out_ch_reg;
    assign results.mean_power        = out_mean_reg;
    assign results.occupancy_percent = out_pct_reg;
    assign results.empty_window      = out_empty_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MEAN || state_reg == ST_PCT) |-> (rem_reg < cnt_reg))
        else $error("Divider remainder is not below the divisor.");

    a_pct_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.occupancy_percent <= PW'(occ_pkg::PERCENT_FULL)))
        else $error("Occupancy percentage exceeds full scale.");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.empty_window) |->
        (results.mean_power == '0 && results.occupancy_percent == '0))
        else $error("Empty window request carries nonzero results.");
`endif

endmodule

// ----- tb/tb_channel_occupancy_estimator.sv -----
// ----------------------------------------------------------------------------
// Channel occupancy estimator testbench
// Drives power sample requests, register writes and result back-pressure.
// A cycle-free model predicts each window summary, and every result request
// is checked field by field against it. The run covers several threshold
// settings, spare register indexes and a stall with the output held off.
// ----------------------------------------------------------------------------
module tb_channel_occupancy_estimator;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 600;
    localparam int IDLE_LIMIT    = 20000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [occ_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = occ_pkg::CFG_IDX_W'(2);
    localparam logic [occ_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = occ_pkg::CFG_IDX_W'(3);

    typedef struct {
        logic signed [occ_pkg::SAMPLE_BITS-1:0] power;
        logic                                   last;
    } power_sample_t;

    typedef struct {
        logic [occ_pkg::CHAN_W-1:0]             chan;
        logic signed [occ_pkg::SAMPLE_BITS-1:0] mean;
        logic [occ_pkg::PCT_W-1:0]              pct;
        logic                                   empty;
    } window_summary_t;

    logic clk;
    logic rst_n;

    occ_in_if  samples_if ();
    occ_cfg_if cfg_if ();
    occ_out_if results_if ();

    channel_occupancy_estimator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .cfg     (cfg_if),
        .results (results_if)
    );

    power_sample_t   sample_q[$];
    window_summary_t summary_q[$];

    logic signed [occ_pkg::SAMPLE_BITS-1:0] floor_lvl;
    logic signed [occ_pkg::SAMPLE_BITS-1:0] busy_lvl;
    longint                                 power_acc;
    int unsigned                            floor_cnt;
    int unsigned                            busy_cnt;
    logic [occ_pkg::CHAN_W-1:0]             chan_idx;

    int src_idle;
    int rcv_idle;
    logic rcv_hold;
    int mismatches;
    int samples_taken;
    int windows_checked;
    int settings_used;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #HALF_PERIOD clk = ~clk;
    end

    function automatic void accumulate_sample(
        input logic signed [occ_pkg::SAMPLE_BITS-1:0] pwr,
        input logic last);
        window_summary_t res;
        longint avg;
        longint share;
        if (pwr > floor_lvl && floor_cnt < occ_pkg::MAX_WINDOW_DEF)
        begin
            floor_cnt++;
            power_acc += pwr;
        end
        if (pwr > busy_lvl && busy_cnt < occ_pkg::MAX_WINDOW_DEF)
        begin
            busy_cnt++;
        end
        if (last)
        begin
            res.chan = chan_idx;
            if (floor_cnt == 0)
            begin
                res.mean  = '0;
                res.pct   = '0;
                res.empty = 1'b1;
            end
            else
            begin
                avg   = power_acc / longint'(floor_cnt);
                share = longint'(busy_cnt) * occ_pkg::PERCENT_FULL / longint'(floor_cnt);
                if (share > occ_pkg::PERCENT_FULL)
                begin
                    share = occ_pkg::PERCENT_FULL;
                end
                res.mean  = avg[occ_pkg::SAMPLE_BITS-1:0];
                res.pct   = share[occ_pkg::PCT_W-1:0];
                res.empty = 1'b0;
            end
            summary_q.push_back(res);
            power_acc = 0;
            floor_cnt = 0;
            busy_cnt  = 0;
            chan_idx  = chan_idx + 1'b1;
        end
    endfunction

    function automatic logic signed [occ_pkg::SAMPLE_BITS-1:0] pick_power();
        int pick;
        int lvl;
        int v;
        pick = $urandom_range(9);
        if (pick < 4)
        begin
            return occ_pkg::SAMPLE_BITS'($urandom);
        end
        if (pick == 9)
        begin
            return ($urandom_range(1) != 0) ? occ_pkg::SAMPLE_BITS'(4095)
                                            : occ_pkg::SAMPLE_BITS'(-4096);
        end
        lvl = (pick < 7) ? int'(floor_lvl) : int'(busy_lvl);
        v = lvl + int'($urandom_range(40)) - 20;
        if (v > 4095)
        begin
            v = 4095;
        end
        if (v < -4096)
        begin
            v = -4096;
        end
        return occ_pkg::SAMPLE_BITS'(v);
    endfunction

    task automatic push_sample(input int pwr, input logic last);
        power_sample_t it;
        it.power = occ_pkg::SAMPLE_BITS'(pwr);
        it.last  = last;
        sample_q.push_back(it);
    endtask

    task automatic push_random_windows(input int n_items);
        int pushed;
        int len;
        pushed = 0;
        while (pushed < n_items)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                push_sample(pick_power(), i == len - 1);
            end
            pushed += len;
        end
    endtask

    task automatic wait_for_drain();
        do @(negedge clk);
        while (sample_q.size() != 0 || samples_if.valid || summary_q.size() != 0);
    endtask

    task automatic settle();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [occ_pkg::CFG_IDX_W-1:0] idx,
                             input logic [occ_pkg::SAMPLE_BITS-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            occ_pkg::REG_NOISE_FLOOR: floor_lvl = signed'(val);
            occ_pkg::REG_BUSY_LEVEL:  busy_lvl  = signed'(val);
            default: ;
        endcase
    endtask

    task automatic set_levels(input logic [occ_pkg::SAMPLE_BITS-1:0] fl,
                              input logic [occ_pkg::SAMPLE_BITS-1:0] bl);
        write_reg(occ_pkg::REG_NOISE_FLOOR, fl);
        write_reg(occ_pkg::REG_BUSY_LEVEL, bl);
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        power_sample_t nxt;
        if (!rst_n)
        begin
            samples_if.valid <= 1'b0;
        end
        else
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                accumulate_sample(samples_if.sample_power, samples_if.window_end);
                samples_taken++;
            end
            if (!samples_if.valid || samples_if.ready)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= src_idle)
                begin
                    nxt = sample_q.pop_front();
                    samples_if.valid        <= 1'b1;
                    samples_if.sample_power <= nxt.power;
                    samples_if.window_end   <= nxt.last;
                end
                else
                begin
                    samples_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        window_summary_t want;
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                windows_checked++;
                if (summary_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("unexpected result: chan %0d mean %0d pct %0d empty %0b",
                                 results_if.channel_number, results_if.mean_power,
                                 results_if.occupancy_percent, results_if.empty_window);
                    end
                end
                else
                begin
                    want = summary_q.pop_front();
                    if (results_if.channel_number !== want.chan
                            || results_if.mean_power !== want.mean
                            || results_if.occupancy_percent !== want.pct
                            || results_if.empty_window !== want.empty)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("mismatch: expected chan %0d mean %0d pct %0d empty %0b",
                                     want.chan, want.mean, want.pct, want.empty);
                            $display("          actual   chan %0d mean %0d pct %0d empty %0b",
                                     results_if.channel_number, results_if.mean_power,
                                     results_if.occupancy_percent, results_if.empty_window);
                        end
                    end
                end
            end
            results_if.ready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples_if.valid && samples_if.ready) || (cfg_if.valid && cfg_if.ready)
                    || (results_if.valid && results_if.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles == IDLE_LIMIT)
            begin
                $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n                   = 1'b0;
        samples_if.valid        = 1'b0;
        samples_if.sample_power = '0;
        samples_if.window_end   = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = '0;
        cfg_if.data             = '0;
        results_if.ready        = 1'b0;
        rcv_hold                = 1'b0;
        floor_lvl               = occ_pkg::FLOOR_RESET;
        busy_lvl                = occ_pkg::BUSY_RESET;
        power_acc               = 0;
        floor_cnt               = 0;
        busy_cnt                = 0;
        chan_idx                = '0;
        mismatches              = 0;
        samples_taken           = 0;
        windows_checked         = 0;
        settings_used           = 1;
        idle_cycles             = 0;
        src_idle                = 36;
        rcv_idle                = 81;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset levels: empty window, extremes, ties with both levels, negative mean.
        push_sample(-4096, 1'b1);
        push_sample(4095, 1'b0);
        push_sample(-4096, 1'b0);
        push_sample(-2400, 1'b0);
        push_sample(-2399, 1'b0);
        push_sample(-1360, 1'b0);
        push_sample(-1359, 1'b1);
        push_sample(-2001, 1'b0);
        push_sample(-2000, 1'b1);
        push_sample(0, 1'b0);
        push_sample(0, 1'b0);
        push_sample(0, 1'b1);
        push_sample(4095, 1'b1);
        push_sample(-4095, 1'b1);
        push_sample(-1, 1'b0);
        push_sample(-2, 1'b1);
        push_random_windows(280);
        settle();

        src_idle = 81;
        rcv_idle = 36;
        set_levels(occ_pkg::SAMPLE_BITS'(-4096), occ_pkg::SAMPLE_BITS'(4095));
        push_random_windows(220);
        settle();

        write_reg(occ_pkg::REG_NOISE_FLOOR, occ_pkg::SAMPLE_BITS'(4095));
        write_reg(occ_pkg::REG_BUSY_LEVEL, occ_pkg::SAMPLE_BITS'(-4096));
        write_reg(REG_SPARE_2, occ_pkg::SAMPLE_BITS'(0));
        write_reg(REG_SPARE_3, occ_pkg::SAMPLE_BITS'(0));
        cfg_if.valid <= 1'b0;
        settings_used++;
        push_random_windows(60);
        settle();

        // Busy level below the floor: the percentage saturates at full scale.
        set_levels(occ_pkg::SAMPLE_BITS'(0), occ_pkg::SAMPLE_BITS'(-100));
        push_sample(-50, 1'b0);
        push_sample(10, 1'b1);
        push_sample(-100, 1'b0);
        push_sample(0, 1'b0);
        push_sample(1, 1'b1);
        push_random_windows(220);
        settle();

        src_idle = 0;
        rcv_idle = 0;
        set_levels(occ_pkg::SAMPLE_BITS'($urandom), occ_pkg::SAMPLE_BITS'($urandom));
        fork
            begin
                rcv_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rcv_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
        begin
            push_sample(pick_power(), 1'b1);
        end
        settle();

        set_levels(occ_pkg::FLOOR_RESET, occ_pkg::BUSY_RESET);
        push_random_windows(120);
        settle();

        mismatches += summary_q.size();
        $display("Run covered %0d samples and %0d windows over %0d threshold settings,",
                 samples_taken, windows_checked, settings_used);
        $display("including spare register writes and an output stall; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
